FILE: rtl/core/psst_pkg.sv
// Shared types and codes for the priority-sorted subscriber table.
// No dependencies; the cell and the top level import it.
package psst_pkg;

  localparam logic ACT_SUBSCRIBE = 1'b0;
  localparam logic ACT_CANCEL    = 1'b1;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_HALTED   = 3'd4;

  typedef struct packed {
    logic        action;
    logic [7:0]  event_id;
    logic [7:0]  priority_req;
    logic [15:0] handler;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] position;
    logic [3:0] count;
  } rsp_t;

  typedef struct packed {
    logic        rd;
    logic        sub;
    logic        cxl;
    logic [15:0] handler;
    logic [7:0]  prio;
  } cell_cmd_t;

  typedef struct packed {
    logic [15:0] handler;
    logic [7:0]  prio;
    logic        le;
    logic        found;
  } cell_link_t;

endpackage

FILE: rtl/core/psst_cell.sv
// One list slot for every event: a small memory, its compare logic and the
// links to both neighbors. Depends on psst_pkg.
module psst_cell #(
  parameter int EVENT_COUNT = 8,
  parameter int LIST_DEPTH  = 8,
  parameter int IDX         = 0,
  parameter int EW          = (EVENT_COUNT > 1) ? $clog2(EVENT_COUNT) : 1,
  parameter int CW          = $clog2(LIST_DEPTH + 1)
) (
  input  logic                   clk,
  input  psst_pkg::cell_cmd_t    cmd,
  input  logic [EW-1:0]          raddr,
  input  logic [EW-1:0]          waddr,
  input  logic [CW-1:0]          n,
  input  psst_pkg::cell_link_t   left,
  input  psst_pkg::cell_link_t   right,
  output psst_pkg::cell_link_t   link,
  output logic                   sel
);
  import psst_pkg::*;

  logic [15:0] mem_h [EVENT_COUNT];
  logic [7:0]  mem_p [EVENT_COUNT];
  logic [15:0] rd_h;
  logic [7:0]  rd_p;
  logic        occupied;
  logic        le;
  logic        match;
  logic        in_range;
  logic        wen;
  logic [15:0] wdata_h;
  logic [7:0]  wdata_p;

  always_comb begin
    occupied = CW'(IDX) < n;
    in_range = CW'(IDX) <= n;
    le       = occupied && (cmd.prio >= rd_p);
    match    = occupied && (rd_h == cmd.handler);
    link.handler = rd_h;
    link.prio    = rd_p;
    link.le      = le;
    link.found   = left.found | match;
    if (cmd.sub) begin
      wen     = !le && in_range;
      wdata_h = left.le ? cmd.handler : left.handler;
      wdata_p = left.le ? cmd.prio : left.prio;
      sel     = !le && in_range && left.le;
    end else begin
      wen     = cmd.cxl && (left.found || match) && (CW'(IDX + 1) < n);
      wdata_h = right.handler;
      wdata_p = right.prio;
      sel     = cmd.cxl && match && !left.found;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_h <= mem_h[raddr];
      rd_p <= mem_p[raddr];
    end
    if (wen) begin
      mem_h[waddr] <= wdata_h;
      mem_p[waddr] <= wdata_p;
    end
  end

endmodule

FILE: rtl/core/priority_sorted_subscriber_table_top.sv
// Top level of the priority-sorted subscriber table: request register,
// count store, halted flag, result register and the chain of psst_cell.
// Depends on psst_pkg and psst_cell.
//
//   channel | signals                     | word
//   --------+-----------------------------+-------------------------------
//   request | req_valid, req_ready, req   | action, event_id, prio, handler
//   result  | rsp_valid, rsp_ready, rsp   | status, position, count
//
// Each word is read, then written: accepting it reads the addressed list out
// of every cell's memory, and firing it compares, shifts and writes.
// One word is in work at a time; a new word is taken while a result waits.
// A stalled result delays the compare and write until the result register frees.
// Reset (rst, synchronous) clears the counts, the halted flag and the handshakes.
module priority_sorted_subscriber_table_top #(
  parameter int EVENT_COUNT = 8,
  parameter int LIST_DEPTH  = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  psst_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output psst_pkg::rsp_t  rsp
);
  import psst_pkg::*;

  localparam int EW = (EVENT_COUNT > 1) ? $clog2(EVENT_COUNT) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int PW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  logic          busy;
  logic          halted;
  req_t          item;
  logic [CW-1:0] cnt_mem [EVENT_COUNT];
  logic [EVENT_COUNT-1:0] cnt_vld;
  logic [CW-1:0] cnt_rd;
  logic          cnt_rd_vld;

  logic          accept;
  logic          fire;
  logic          ev_ok;
  logic [EW-1:0] evi;
  logic [CW-1:0] n;
  logic [CW-1:0] n_next;
  logic          go_sub;
  logic          go_cxl;
  logic          cnt_we;
  logic          halt_set;
  rsp_t          rsp_next;
  logic [PW-1:0] pos;
  cell_cmd_t     cmd;

  cell_link_t             links [LIST_DEPTH];
  logic [LIST_DEPTH-1:0]  sel;

  assign req_ready = !busy;
  assign accept    = req_valid && req_ready;
  assign fire      = busy && (!rsp_valid || rsp_ready);
  assign ev_ok     = item.event_id < 8'(EVENT_COUNT);
  assign evi       = item.event_id[EW-1:0];
  assign n         = (ev_ok && cnt_rd_vld) ? cnt_rd : '0;

  always_comb begin
    go_sub = 1'b0;
    go_cxl = 1'b0;
    if (fire && !halted && ev_ok && item.handler != 16'd0) begin
      if (item.action == ACT_SUBSCRIBE) begin
        go_sub = n < CW'(LIST_DEPTH);
      end else begin
        go_cxl = 1'b1;
      end
    end
    cmd.rd      = accept;
    cmd.sub     = go_sub;
    cmd.cxl     = go_cxl;
    cmd.handler = item.handler;
    cmd.prio    = item.priority_req;
  end

  genvar gi;
  generate
    for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
      cell_link_t left_in;
      cell_link_t right_in;
      if (gi == 0) begin : g_first
        assign left_in = '{handler: 16'd0, prio: 8'd0, le: 1'b1, found: 1'b0};
      end else begin : g_mid
        assign left_in = links[gi-1];
      end
      if (gi == LIST_DEPTH - 1) begin : g_last
        assign right_in = '0;
      end else begin : g_inner
        assign right_in = links[gi+1];
      end
      psst_cell #(
        .EVENT_COUNT(EVENT_COUNT),
        .LIST_DEPTH (LIST_DEPTH),
        .IDX        (gi),
        .EW         (EW),
        .CW         (CW)
      ) u_cell (
        .clk  (clk),
        .cmd  (cmd),
        .raddr(req.event_id[EW-1:0]),
        .waddr(evi),
        .n    (n),
        .left (left_in),
        .right(right_in),
        .link (links[gi]),
        .sel  (sel[gi])
      );
    end
  endgenerate

  always_comb begin
    pos = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (sel[i]) begin
        pos = pos | PW'(i);
      end
    end
  end

  always_comb begin
    rsp_next.status   = ST_DONE;
    rsp_next.position = 3'd0;
    n_next            = n;
    cnt_we            = 1'b0;
    halt_set          = 1'b0;
    if (halted) begin
      rsp_next.status = ST_HALTED;
    end else if (!ev_ok || item.handler == 16'd0) begin
      rsp_next.status = ST_INVALID;
    end else if (item.action == ACT_SUBSCRIBE) begin
      if (!go_sub) begin
        rsp_next.status = ST_OVERFLOW;
        halt_set        = fire;
      end else begin
        rsp_next.position = 3'(pos);
        n_next            = n + CW'(1);
        cnt_we            = 1'b1;
      end
    end else if (!links[LIST_DEPTH-1].found) begin
      rsp_next.status = ST_NOTFOUND;
    end else begin
      rsp_next.position = 3'(pos);
      n_next            = n - CW'(1);
      cnt_we            = go_cxl;
    end
    rsp_next.count = 4'(n_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      halted    <= 1'b0;
      rsp_valid <= 1'b0;
      cnt_vld   <= '0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (fire) begin
        busy <= 1'b0;
      end
      if (halt_set) begin
        halted <= 1'b1;
      end
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cnt_we && fire) begin
        cnt_vld[evi] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item       <= req;
      cnt_rd     <= cnt_mem[req.event_id[EW-1:0]];
      cnt_rd_vld <= cnt_vld[req.event_id[EW-1:0]];
    end
    if (cnt_we && fire) begin
      cnt_mem[evi] <= n_next;
    end
    if (fire) begin
      rsp <= rsp_next;
    end
  end

endmodule

FILE: test/testbench.sv
// Self-checking testbench for priority_sorted_subscriber_table_top.
// Depends on psst_pkg and the RTL; a scoreboard class predicts each result word
// from its own handler lists; a task drives requests and a loop drives rsp_ready.
`timescale 1ns / 1ps

import psst_pkg::*;

localparam int EVENT_COUNT = 8;
localparam int LIST_DEPTH  = 8;

class subscriber_lists;
  logic [15:0] handlers [EVENT_COUNT][LIST_DEPTH];
  logic [7:0]  prios    [EVENT_COUNT][LIST_DEPTH];
  int          counts   [EVENT_COUNT];
  bit          halted;
  rsp_t        pending_results [$];
  int          mismatches;
  int          checked;

  function int count_of(int ev);
    return counts[ev];
  endfunction

  function logic [15:0] handler_at(int ev, int slot);
    return handlers[ev][slot];
  endfunction

  function void apply_request(req_t w);
    rsp_t want;
    int   ev;
    int   n;
    int   pos;
    bit   ev_ok;
    ev = w.event_id;
    ev_ok = ev < EVENT_COUNT;
    n = ev_ok ? counts[ev] : 0;
    want.status = ST_DONE;
    want.position = '0;
    want.count = 4'(n);
    if (halted) begin
      want.status = ST_HALTED;
    end else if (!ev_ok || w.handler == '0) begin
      want.status = ST_INVALID;
    end else if (w.action == ACT_SUBSCRIBE) begin
      if (n >= LIST_DEPTH) begin
        halted = 1'b1;
        want.status = ST_OVERFLOW;
      end else begin
        pos = 0;
        while (pos < n && w.priority_req >= prios[ev][pos]) pos++;
        for (int i = n; i > pos; i--) begin
          handlers[ev][i] = handlers[ev][i-1];
          prios[ev][i] = prios[ev][i-1];
        end
        handlers[ev][pos] = w.handler;
        prios[ev][pos] = w.priority_req;
        counts[ev] = n + 1;
        want.position = 3'(pos);
        want.count = 4'(n + 1);
      end
    end else begin
      pos = 0;
      while (pos < n && handlers[ev][pos] != w.handler) pos++;
      if (pos >= n) begin
        want.status = ST_NOTFOUND;
      end else begin
        for (int i = pos; i + 1 < n; i++) begin
          handlers[ev][i] = handlers[ev][i+1];
          prios[ev][i] = prios[ev][i+1];
        end
        counts[ev] = n - 1;
        want.position = 3'(pos);
        want.count = 4'(n - 1);
      end
    end
    pending_results.push_back(want);
  endfunction

  function void check_result(rsp_t got);
    rsp_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected result word: status %0d position %0d count %0d",
                 got.status, got.position, got.count);
      end
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status || got.position !== want.position ||
        got.count !== want.count) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result word %0d: expected status %0d position %0d count %0d, got %0d %0d %0d",
                 checked, want.status, want.position, want.count,
                 got.status, got.position, got.count);
      end
    end
    checked++;
  endfunction
endclass

module testbench;
  localparam int ITEMS       = 800;
  localparam int QUIET_LIMIT = 2000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  logic rsp_valid;
  logic rsp_ready;
  req_t req;
  rsp_t rsp;

  int send_idle_pct = 15;
  int recv_idle_pct = 47;
  int stall_left = 0;
  int quiet_cycles = 0;
  subscriber_lists lists = new;

  priority_sorted_subscriber_table_top #(
    .EVENT_COUNT(EVENT_COUNT),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        rsp_ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) lists.check_result(rsp);
      if (req_valid && req_ready) lists.apply_request(req);
    end
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic req_t make_word(logic act, int ev, int prio, int hnd);
    req_t w;
    w.action = act;
    w.event_id = 8'(ev);
    w.priority_req = 8'(prio);
    w.handler = 16'(hnd);
    return w;
  endfunction

  function automatic req_t random_word();
    req_t       w;
    int         ev;
    int         n;
    int         roll;
    logic [7:0] corner [4] = '{8'h00, 8'h7F, 8'h80, 8'hFF};
    roll = $urandom_range(0, 99);
    ev = $urandom_range(0, EVENT_COUNT - 1);
    n = lists.count_of(ev);
    w.event_id = 8'(ev);
    w.priority_req = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 255))
                                                  : corner[$urandom_range(0, 3)];
    w.handler = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 4))
                                             : 16'($urandom_range(1, 65535));
    if (n == 0 || (n < LIST_DEPTH && $urandom_range(0, 99) < 55)) begin
      w.action = ACT_SUBSCRIBE;
    end else begin
      w.action = ACT_CANCEL;
      if ($urandom_range(0, 3) != 0) begin
        w.handler = lists.handler_at(ev, $urandom_range(0, n - 1));
      end
    end
    if (roll < 4) begin
      w.event_id = 8'($urandom_range(EVENT_COUNT, 255));
    end else if (roll < 8) begin
      w.handler = '0;
    end
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input req_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  initial begin
    req_t directed [$];
    req_t w;
    int   sent;
    int   phase;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    directed.push_back(make_word(ACT_SUBSCRIBE, 0, 8'h80, 16'h0001));
    directed.push_back(make_word(ACT_SUBSCRIBE, 0, 8'h80, 16'h0002));
    directed.push_back(make_word(ACT_SUBSCRIBE, 0, 8'h00, 16'hFFFF));
    directed.push_back(make_word(ACT_SUBSCRIBE, 0, 8'hFF, 16'h8000));
    directed.push_back(make_word(ACT_SUBSCRIBE, 0, 8'h80, 16'h0001));
    directed.push_back(make_word(ACT_CANCEL, 0, 8'h00, 16'h0001));
    directed.push_back(make_word(ACT_CANCEL, 0, 8'hFF, 16'h1234));
    directed.push_back(make_word(ACT_CANCEL, 7, 8'h00, 16'h0001));
    directed.push_back(make_word(ACT_SUBSCRIBE, EVENT_COUNT, 8'h10, 16'h0005));
    directed.push_back(make_word(ACT_SUBSCRIBE, 255, 8'hFF, 16'hFFFF));
    directed.push_back(make_word(ACT_CANCEL, 128, 8'h00, 16'h0002));
    directed.push_back(make_word(ACT_SUBSCRIBE, 0, 8'h40, 16'h0000));
    directed.push_back(make_word(ACT_CANCEL, 0, 8'h40, 16'h0000));
    for (int k = 0; k < LIST_DEPTH; k++) begin
      directed.push_back(make_word(ACT_SUBSCRIBE, 7, 255 - 32 * k, 16'h0100 + k));
    end
    directed.push_back(make_word(ACT_CANCEL, 7, 8'h00, 16'h0100));
    foreach (directed[i]) send_word(directed[i]);

    send_idle_pct = 15;
    recv_idle_pct = 47;
    sent = 0;
    phase = 0;
    while (sent < ITEMS) begin
      if (phase == 0 && sent >= ITEMS / 3) begin
        phase = 1;
        send_idle_pct = 47;
        recv_idle_pct = 15;
      end else if (phase == 1 && sent >= 2 * ITEMS / 3) begin
        // Hold the result channel off long enough for the request side to back up.
        phase = 2;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_left = 300;
      end
      w = random_word();
      send_word(w);
      sent++;
    end

    // Fill one list and overflow it; every word after that must report halted.
    while (lists.count_of(3) < LIST_DEPTH) begin
      send_word(make_word(ACT_SUBSCRIBE, 3, $urandom_range(0, 255), $urandom_range(1, 65535)));
    end
    send_word(make_word(ACT_SUBSCRIBE, 3, 8'h10, 16'h0042));
    send_word(make_word(ACT_CANCEL, 3, 8'h00, lists.handler_at(3, 0)));
    send_word(make_word(ACT_SUBSCRIBE, 0, 8'h20, 16'h0077));
    send_word(make_word(ACT_SUBSCRIBE, 200, 8'h20, 16'h0077));
    send_word(make_word(ACT_CANCEL, 1, 8'h00, 16'h0000));
    req_valid <= 1'b0;

    while (lists.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (lists.mismatches == 0 && lists.pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
